[hw/rtl/esp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Transaction payload types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package esp_pkg;

  typedef struct packed {
    logic              func;
    logic signed [31:0] encoder_count;
    logic        [31:0] time_ms;
  } esp_in_t;

  typedef struct packed {
    logic signed [31:0] speed_rev_per_s;
    logic signed [47:0] speed_mm_per_s;
    logic signed [31:0] total_counts;
    logic               stalled;
  } esp_out_t;

  localparam logic FUNC_POLL    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REV = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCUMFERENCE = 8'd3;

  localparam logic [15:0] MIN_WINDOW_RST    = 16'd20;
  localparam logic [15:0] TICKS_PER_REV_RST = 16'd360;
  localparam logic [15:0] STALL_TIMEOUT_RST = 16'd200;
  localparam logic [11:0] CIRCUMFERENCE_RST = 12'd200;

  localparam logic [15:0] MS_PER_S   = 16'd1000;
  localparam logic [15:0] ALPHA_Q16  = 16'd13107;
  localparam logic [47:0] ROUND_HALF = 48'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_MNUM,
    S_MDEN,
    S_DCHK,
    S_DIV,
    S_SAMP,
    S_FDIFF,
    S_FMUL,
    S_FADD,
    S_STALL,
    S_MM,
    S_OUT
  } esp_state_t;

endpackage

[hw/rtl/encoder_speed_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator
// Windowed encoder speed with a first-order low-pass, in rev/s and mm/s.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  in       | in_valid / in_ready   | in_data  (func, count, time)
//  out      | out_valid / out_ready | out_data (speeds, total, stalled)
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A transaction that closes a window runs the restoring divider, one bit per
//  cycle; the divider is skipped when the sample saturates, and a zero net
//  window skips both the products and the divider. in_ready is high only in
//  idle, so no new transaction is taken until the last one is through.
//  One shared 33x16 multiplier serves all products. A result waiting in the
//  output register holds the sequencer in its last step. rst restores defaults.
// ----------------------------------------------------------------------------
module encoder_speed_estimator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  esp_pkg::esp_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output esp_pkg::esp_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [esp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);
  import esp_pkg::*;

  localparam int NUM_W = 41;
  localparam int NW    = NUM_W + FRAC_BITS;
  localparam int TOP_W = NW - 32;

  // configuration
  logic [15:0] min_window;
  logic [15:0] ticks_per_rev;
  logic [15:0] stall_timeout;
  logic [11:0] circumference;

  // estimator state
  logic [31:0] previous_count;
  logic [31:0] count_total;
  logic [31:0] window_counts;
  logic signed [31:0] filtered_speed;
  logic [31:0] window_start_ms;
  logic [31:0] last_tick_ms;

  // working registers
  esp_state_t  state, state_next;
  logic        func;
  logic [31:0] cur;
  logic [31:0] now;
  logic [31:0] dt;
  logic [31:0] w_mag;
  logic        w_neg;
  logic [NUM_W-1:0] num;
  logic [47:0] den;
  logic [47:0] rem;
  logic [31:0] nsh;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        div_sat;
  logic signed [31:0] sample;
  logic [32:0] d_mag;
  logic        d_neg;
  logic [46:0] fprod;
  logic [43:0] mm_mag;
  logic        mm_neg;
  logic        stalled;

  // shared multiplier
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [48:0] mul_p;
  assign mul_p = 49'(mul_a) * 49'(mul_b);

  // poll step decode
  logic [31:0] step;
  logic [31:0] du;
  logic [31:0] wc_new;
  logic [31:0] dt_now;
  logic        moved;
  logic        window_unset;
  logic        window_done;

  always_comb begin
    step = cur - previous_count;
    moved = (step != 32'd0);
    priority if (!step[31] && step[30:15] != 16'd0) begin
      du = 32'h0000_7FFF;
    end else if (step[31] && step[30:15] != 16'hFFFF) begin
      du = 32'hFFFF_8000;
    end else begin
      du = step;
    end
    wc_new = window_counts + du;
    dt_now = now - window_start_ms;
    window_unset = (window_start_ms == 32'd0);
    window_done = !window_unset && (dt_now >= 32'(min_window));
  end

  // divider datapath
  logic [NW-1:0] n_full;
  logic [TOP_W-1:0] n_top;
  logic [48:0] r_sh;
  logic        r_ge;
  logic [31:0] s_mag;
  logic signed [33:0] diff;
  logic [47:0] frnd;
  logic [31:0] dm;
  logic signed [33:0] fsum;
  logic signed [31:0] fsat;

  always_comb begin
    n_full = {num, {FRAC_BITS{1'b0}}};
    n_top = n_full[NW-1:32];
    r_sh = {rem, nsh[31]};
    r_ge = (r_sh >= 49'(den));
    // clamp the quotient to the signed range of the sample
    if (w_neg) begin
      s_mag = (div_sat || quo > 32'h8000_0000) ? 32'h8000_0000 : quo;
    end else begin
      s_mag = (div_sat || quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo;
    end
    diff = 34'(sample) - 34'(filtered_speed);
    frnd = 48'(fprod) + ROUND_HALF;
    dm = frnd[47:16];
    if (d_neg) begin
      fsum = 34'(filtered_speed) - 34'(dm);
    end else begin
      fsum = 34'(filtered_speed) + 34'(dm);
    end
    priority if (fsum > 34'sh0_7FFF_FFFF) begin
      fsat = 32'sh7FFF_FFFF;
    end else if (fsum < -34'sh0_8000_0000) begin
      fsat = 32'sh8000_0000;
    end else begin
      fsat = fsum[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_STEP;
      S_STEP: begin
        if (func == FUNC_RESTART) begin
          state_next = S_MM;
        end else if (moved && window_done) begin
          state_next = (wc_new == 32'd0) ? S_FDIFF : S_MNUM;
        end else begin
          state_next = S_STALL;
        end
      end
      S_MNUM:  state_next = S_MDEN;
      S_MDEN:  state_next = S_DCHK;
      S_DCHK:  state_next = (den == 48'd0 || 48'(n_top) >= den) ? S_SAMP : S_DIV;
      S_DIV:   if (cnt == 5'd31) state_next = S_SAMP;
      S_SAMP:  state_next = S_FDIFF;
      S_FDIFF: state_next = S_FMUL;
      S_FMUL:  state_next = S_FADD;
      S_FADD:  state_next = S_STALL;
      S_STALL: state_next = S_MM;
      S_MM:    state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state == S_IDLE);
    cfg_ready = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MNUM: begin
        mul_a = 33'(w_mag);
        mul_b = MS_PER_S;
      end
      S_MDEN: begin
        mul_a = 33'(dt);
        mul_b = ticks_per_rev;
      end
      S_FMUL: begin
        mul_a = d_mag;
        mul_b = ALPHA_Q16;
      end
      S_MM: begin
        mul_a = filtered_speed[31] ? 33'(-filtered_speed) : 33'(filtered_speed);
        mul_b = 16'(circumference);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_window    <= MIN_WINDOW_RST;
      ticks_per_rev <= TICKS_PER_REV_RST;
      stall_timeout <= STALL_TIMEOUT_RST;
      circumference <= CIRCUMFERENCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MIN_WINDOW) min_window <= cfg_data;
      if (cfg_index == REG_TICKS_PER_REV) ticks_per_rev <= cfg_data;
      if (cfg_index == REG_STALL_TIMEOUT) stall_timeout <= cfg_data;
      if (cfg_index == REG_CIRCUMFERENCE) circumference <= cfg_data[11:0];
    end
  end

  // estimator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count  <= '0;
      count_total     <= '0;
      window_counts   <= '0;
      filtered_speed  <= '0;
      window_start_ms <= '0;
      last_tick_ms    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func <= in_data.func;
            cur  <= in_data.encoder_count;
            now  <= in_data.time_ms;
          end
        end
        S_STEP: begin
          stalled <= 1'b0;
          if (func == FUNC_RESTART) begin
            previous_count  <= cur;
            count_total     <= '0;
            window_counts   <= '0;
            filtered_speed  <= '0;
            window_start_ms <= '0;
            last_tick_ms    <= '0;
          end else if (moved) begin
            previous_count <= cur;
            last_tick_ms   <= now;
            count_total    <= count_total + du;
            if (window_unset) begin
              window_start_ms <= now;
              window_counts   <= wc_new;
            end else if (window_done) begin
              // close the window: latch its magnitude, restart accumulation
              window_start_ms <= now;
              window_counts   <= '0;
              dt     <= dt_now;
              w_neg  <= wc_new[31];
              w_mag  <= wc_new[31] ? -wc_new : wc_new;
              sample <= '0;
            end else begin
              window_counts <= wc_new;
            end
          end
        end
        S_MNUM: num <= mul_p[NUM_W-1:0];
        S_MDEN: den <= mul_p[47:0];
        S_DCHK: begin
          div_sat <= (den == 48'd0 || 48'(n_top) >= den);
          rem <= 48'(n_top);
          nsh <= n_full[31:0];
          quo <= '0;
          cnt <= '0;
        end
        S_DIV: begin
          rem <= r_ge ? 48'(r_sh - 49'(den)) : r_sh[47:0];
          nsh <= {nsh[30:0], 1'b0};
          quo <= {quo[30:0], r_ge};
          cnt <= cnt + 5'd1;
        end
        S_SAMP: sample <= w_neg ? -s_mag : s_mag;
        S_FDIFF: begin
          d_neg <= diff[33];
          d_mag <= diff[33] ? 33'(-diff) : 33'(diff);
        end
        S_FMUL: fprod <= mul_p[46:0];
        S_FADD: filtered_speed <= fsat;
        S_STALL: begin
          if (last_tick_ms != 32'd0 && (now - last_tick_ms) > 32'(stall_timeout)) begin
            filtered_speed <= '0;
            stalled <= 1'b1;
          end
        end
        S_MM: begin
          mm_mag <= mul_p[43:0];
          mm_neg <= filtered_speed[31];
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.speed_rev_per_s <= filtered_speed;
            out_data.speed_mm_per_s  <= mm_neg ? -48'(mm_mag) : 48'(mm_mag);
            out_data.total_counts    <= count_total;
            out_data.stalled         <= stalled;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[dv/encoder_speed_estimator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator testbench
// Drives poll and restart transactions through the input channel and rewrites
// the registers between phases. Each accepted transaction is run through an
// in-bench estimator that predicts speed, linear speed, total and stall flag,
// and every result is checked field by field against the oldest prediction.
// Both channels idle at random. One phase holds the output off for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module encoder_speed_estimator_tb;
  import esp_pkg::*;

  localparam int              Q_FRAC         = 16;
  localparam longint unsigned LP_ALPHA       = 13107;
  localparam longint unsigned LP_ROUND       = 32768;
  localparam longint unsigned MS_SCALE       = 1000;
  localparam longint unsigned RATE_OVERFLOW  = 64'hF_FFFF_FFFF;
  localparam longint          S32_MAX        = 64'sd2147483647;
  localparam longint          S32_MIN        = -64'sd2147483648;
  localparam int              CLAMP_HI       = 32767;
  localparam int              CLAMP_LO       = -32768;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFC;
  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              HOLD_CYCLES    = 400;
  localparam int              DRAIN_CYCLES   = 60;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  esp_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  esp_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  encoder_speed_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Estimator copy of registers and state
  logic [15:0]        est_min_window = MIN_WINDOW_RST;
  logic [15:0]        est_cpr        = TICKS_PER_REV_RST;
  logic [15:0]        est_stall_to   = STALL_TIMEOUT_RST;
  logic [11:0]        est_circ       = CIRCUMFERENCE_RST;
  logic [31:0]        est_prev       = '0;
  logic [31:0]        est_total      = '0;
  logic [31:0]        est_window     = '0;
  logic [31:0]        est_win_start  = '0;
  logic [31:0]        est_last_tick  = '0;
  logic signed [31:0] est_speed      = '0;

  esp_out_t expected_results[$];
  int       mismatches  = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  bit       hold_req    = 1'b0;

  // Window count over dt as rev/s in Q16.16, truncated, saturated
  function automatic logic signed [31:0] window_rate(logic [31:0] win, logic [31:0] dt);
    longint          w;
    longint unsigned mag_w, num, den, mag;
    logic [63:0]     neg_mag;
    w = longint'($signed(win));
    mag_w = (w < 0) ? -w : w;
    if (mag_w == 0) return '0;
    num = mag_w * MS_SCALE;
    den = {48'b0, est_cpr} * {32'b0, dt};
    if (den == 0) begin
      mag = RATE_OVERFLOW;
    end else begin
      mag = (num << Q_FRAC) / den;
      if (mag >= 64'h1_0000_0000) mag = RATE_OVERFLOW;
    end
    if (w < 0) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      neg_mag = 64'd0 - mag;
      return neg_mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Low-pass by alpha, magnitude rounded half away from zero
  function automatic logic signed [31:0] low_pass(logic signed [31:0] sample);
    longint          diff, delta, sum;
    longint unsigned m, dm;
    diff = longint'(sample) - longint'(est_speed);
    m = (diff < 0) ? -diff : diff;
    dm = (m * LP_ALPHA + LP_ROUND) >> 16;
    delta = (diff < 0) ? -longint'(dm) : longint'(dm);
    sum = longint'(est_speed) + delta;
    if (sum > S32_MAX) return S32_MAX[31:0];
    if (sum < S32_MIN) return S32_MIN[31:0];
    return sum[31:0];
  endfunction

  function automatic esp_out_t estimate_result(esp_in_t item);
    logic [31:0] cur, now_ms, step32, dt;
    longint      d, mm;
    logic        stalled;
    esp_out_t    r;
    cur = item.encoder_count;
    now_ms = item.time_ms;
    stalled = 1'b0;
    if (item.func == FUNC_RESTART) begin
      est_total     = '0;
      est_window    = '0;
      est_speed     = '0;
      est_win_start = '0;
      est_last_tick = '0;
      est_prev      = cur;
    end else begin
      step32 = cur - est_prev;
      d = longint'($signed(step32));
      if (d != 0) begin
        if (d > CLAMP_HI) d = CLAMP_HI;
        if (d < CLAMP_LO) d = CLAMP_LO;
        est_total  = est_total + d[31:0];
        est_window = est_window + d[31:0];
        // zero start time means the window is not open yet
        if (est_win_start == 0) begin
          est_win_start = now_ms;
        end else begin
          dt = now_ms - est_win_start;
          if (dt >= {16'b0, est_min_window}) begin
            est_win_start = now_ms;
            est_speed = low_pass(window_rate(est_window, dt));
            est_window = '0;
          end
        end
        est_prev = cur;
        est_last_tick = now_ms;
      end
      step32 = now_ms - est_last_tick;
      if (est_last_tick != 0 && step32 > {16'b0, est_stall_to}) begin
        est_speed = '0;
        stalled = 1'b1;
      end
    end
    mm = longint'(est_speed) * longint'({52'b0, est_circ});
    r.speed_rev_per_s = est_speed;
    r.speed_mm_per_s  = mm[47:0];
    r.total_counts    = est_total;
    r.stalled         = stalled;
    return r;
  endfunction

  // Track register writes and accepted transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_WINDOW:    est_min_window = cfg_data;
          REG_TICKS_PER_REV: est_cpr        = cfg_data;
          REG_STALL_TIMEOUT: est_stall_to   = cfg_data;
          REG_CIRCUMFERENCE: est_circ       = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(estimate_result(in_data));
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    esp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_data.total_counts), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.speed_rev_per_s !== want.speed_rev_per_s)
          report_mismatch("speed_rev_per_s", 64'(out_data.speed_rev_per_s),
                          64'(want.speed_rev_per_s));
        if (out_data.speed_mm_per_s !== want.speed_mm_per_s)
          report_mismatch("speed_mm_per_s", 64'(out_data.speed_mm_per_s),
                          64'(want.speed_mm_per_s));
        if (out_data.total_counts !== want.total_counts)
          report_mismatch("total_counts", 64'(out_data.total_counts),
                          64'(want.total_counts));
        if (out_data.stalled !== want.stalled)
          report_mismatch("stalled", 64'(out_data.stalled), 64'(want.stalled));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: modes of always ready, coin flip and mostly stalled
  initial begin : receiver
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 120);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic f, logic [31:0] cnt, logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{func: f, encoder_count: cnt, time_ms: t};
    do @(posedge clk); while (!in_ready);
  endtask

  // Write only with nothing in flight; every transaction yields a result
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] min_win, logic [15:0] cpr, logic [15:0] stall_to,
                            logic [15:0] circ);
    write_reg(REG_MIN_WINDOW, min_win);
    write_reg(REG_TICKS_PER_REV, cpr);
    write_reg(REG_STALL_TIMEOUT, stall_to);
    write_reg(REG_CIRCUMFERENCE, circ);
  endtask

  // Reset registers: time-zero tick, window open, no change, both signs, stall
  task automatic test_window_and_stall;
    send_item(FUNC_RESTART, 32'd0, 32'd0);
    send_item(FUNC_POLL, 32'd3, 32'd0);
    send_item(FUNC_POLL, 32'd13, 32'd5);
    send_item(FUNC_POLL, 32'd13, 32'd10);
    send_item(FUNC_POLL, 32'd33, 32'd30);
    send_item(FUNC_POLL, 32'd18, 32'd55);
    send_item(FUNC_POLL, 32'd18, 32'd256);
  endtask

  // Count wrap at the signed extremes, step clamping, time wrap
  task automatic test_count_extremes;
    send_item(FUNC_RESTART, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
    send_item(FUNC_POLL, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_POLL, 32'h8000_0000 + 32'd100000, 32'd20);
    send_item(FUNC_POLL, 32'h8000_0000 - 32'd100000, 32'd45);
  endtask

  // Shortest window, one count per rev: sample saturates both ways
  task automatic test_rate_saturation;
    set_config(16'd1, 16'd1, 16'hFFFF, 16'd4095);
    send_item(FUNC_RESTART, 32'd0, 32'd100);
    send_item(FUNC_POLL, 32'd32767, 32'd101);
    send_item(FUNC_POLL, 32'd65534, 32'd102);
    send_item(FUNC_POLL, 32'd0, 32'd103);
  endtask

  // Zero window and zero counts per rev: divisor of zero
  task automatic test_zero_divisor;
    set_config(16'd0, 16'd0, STALL_TIMEOUT_RST, 16'd1);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_item(FUNC_RESTART, 32'd5, 32'd1);
    send_item(FUNC_POLL, 32'd8, 32'd7);
    send_item(FUNC_POLL, 32'd11, 32'd7);
    send_item(FUNC_POLL, 32'd8, 32'd7);
  endtask

  // Mostly coherent runs of polls after a restart, some noise mixed in
  task automatic run_random_phase(int n, logic [15:0] min_win, logic [15:0] cpr,
                                  logic [15:0] stall_to, logic [15:0] circ,
                                  int step_max, bit with_hold);
    logic [31:0] cur_count, cur_time, step_ms, delta;
    int          pick, r;
    set_config(min_win, cpr, stall_to, circ);
    cur_count = '0;
    cur_time  = '0;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 10) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 4) begin
        cur_count = $urandom;
        cur_time = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
                                               : $urandom;
        send_item(FUNC_RESTART, cur_count, cur_time);
      end else if (pick < 10) begin
        send_item(FUNC_POLL, $urandom, (pick < 6) ? 32'd0 : $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5)
          step_ms = {16'b0, stall_to} + $urandom_range(1, 300);
        else if (r < 10)
          step_ms = '0;
        else
          step_ms = $urandom_range(1, step_max);
        cur_time = cur_time + step_ms;
        r = $urandom_range(0, 99);
        if (r < 20)
          delta = '0;
        else if (r < 25)
          delta = $urandom;
        else
          delta = 32'($urandom_range(0, 600)) - 32'd300;
        cur_count = cur_count + delta;
        send_item(FUNC_POLL, cur_count, cur_time);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_window_and_stall;
    test_count_extremes;
    test_rate_saturation;
    test_zero_divisor;
    run_random_phase(90, MIN_WINDOW_RST, TICKS_PER_REV_RST, STALL_TIMEOUT_RST,
                     16'(CIRCUMFERENCE_RST), 40, 1'b1);
    run_random_phase(80, 16'd1, 16'd1, 16'd1, 16'd4095, 4, 1'b0);
    run_random_phase(80, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20000, 1'b0);
    run_random_phase(80, 16'd0, 16'd0, 16'd50, 16'd1, 10, 1'b0);
    run_random_phase(90, 16'($urandom_range(1, 64)), 16'($urandom_range(1, 4096)),
                     16'($urandom_range(20, 1000)), 16'($urandom_range(1, 4095)), 50, 1'b0);
    run_random_phase(90, 16'd5, 16'd100, 16'd30, 16'd1000, 15, 1'b0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hw/rtl/esp_pkg.sv
hw/rtl/encoder_speed_estimator.sv
dv/encoder_speed_estimator_tb.sv
